FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the UV sphere vertex generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define UVS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define UVS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define UVS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define UVS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/uvs_pkg.sv
// Shared types, constants and fixed-point helpers of the UV sphere vertex generator.
`default_nettype none

package uvs_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SECTOR_COUNT  = 2'd0,
        CFG_STACK_COUNT   = 2'd1,
        CFG_SPHERE_RADIUS = 2'd2
    } cfg_index_t;

    localparam logic [8:0]  SECTOR_COUNT_RST  = 9'd36;
    localparam logic [8:0]  STACK_COUNT_RST   = 9'd18;
    localparam logic [15:0] SPHERE_RADIUS_RST = 16'd256;
    localparam logic [8:0]  MIN_SECTORS       = 9'd3;
    localparam logic [8:0]  MIN_STACKS        = 9'd2;

    // Long division: fraction bits produced, and where the texture tap sits
    localparam int DIV_FRAC_BITS = 32;
    localparam int TEX_FRAC_BITS = 16;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

    // atan(2^-k) in 2^-32 turns
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic signed [63:0] POS_LIMIT  = 64'sd65535;
    localparam logic signed [63:0] NORM_LIMIT = 64'sd16384;

    // Arithmetic shift right that truncates toward zero
    function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                       input int unsigned k);
        logic [CW-1:0] mag;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        mag = mag >> k;
        return v[CW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    // Shift right, round to nearest, ties away from zero
    function automatic logic signed [63:0] shr_round64(input logic signed [63:0] v,
                                                       input int unsigned k);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (k - 1))) >> k;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    // Symmetric saturation to +-lim
    function automatic logic signed [63:0] clamp_sym64(input logic signed [63:0] v,
                                                       input logic signed [63:0] lim);
        logic signed [63:0] res;
        res = v;
        if (v > lim) begin
            res = lim;
        end else if (v < -lim) begin
            res = -lim;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/uvs_div.sv
// Pipelined restoring divider: rounded num/den fractions for texture and angle.
`default_nettype none

module uvs_div
    import uvs_pkg::*;
#(
    parameter int ANG_FRAC = 32,
    parameter int TAG_W    = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [8:0]       num,
    input  wire logic [8:0]       den,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_valid,
    output logic [31:0]           out_ang,
    output logic [16:0]           out_tex,
    output logic [TAG_W-1:0]      out_tag
);

    localparam int STAGES = DIV_FRAC_BITS + 1;
    localparam int QW     = DIV_FRAC_BITS + 1;

    logic             vld_reg [STAGES];
    logic [8:0]       rem_reg [STAGES];
    logic [QW-1:0]    quo_reg [STAGES];
    logic [16:0]      tex_reg [STAGES];
    logic [31:0]      ang_reg [STAGES];
    logic [TAG_W-1:0] tag_reg [STAGES];

    logic [7:0] half;
    assign half = den[8:1];

    // Stage 0 gives the integer bit, stage k the k-th fraction bit
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [9:0]       dbl;
        logic [QW-1:0]    quo_prev;
        logic [16:0]      tex_prev;
        logic [31:0]      ang_prev;
        logic [TAG_W-1:0] tag_prev;
        logic             vld_prev;
        logic             ge;
        logic             rnd;
        logic [8:0]       rem_next;
        logic [QW-1:0]    quo_next;
        logic [16:0]      tex_next;
        logic [31:0]      ang_next;

        if (k == 0) begin : g_first
            assign dbl      = {1'b0, num};
            assign quo_prev = '0;
            assign tex_prev = '0;
            assign ang_prev = '0;
            assign tag_prev = in_tag;
            assign vld_prev = in_valid;
        end else begin : g_next
            assign dbl      = {rem_reg[k-1], 1'b0};
            assign quo_prev = quo_reg[k-1];
            assign tex_prev = tex_reg[k-1];
            assign ang_prev = ang_reg[k-1];
            assign tag_prev = tag_reg[k-1];
            assign vld_prev = vld_reg[k-1];
        end

        assign ge       = dbl >= {1'b0, den};
        assign rem_next = ge ? 9'(dbl - {1'b0, den}) : dbl[8:0];
        assign quo_next = {quo_prev[QW-2:0], ge};
        // round up when the remainder reaches half the divisor
        assign rnd      = ({1'b0, rem_next} + {2'b00, half}) >= {1'b0, den};
        assign tex_next = (k == TEX_FRAC_BITS) ? quo_next[16:0] + {16'd0, rnd} : tex_prev;
        assign ang_next = (k == ANG_FRAC) ? quo_next[31:0] + {31'd0, rnd} : ang_prev;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                tex_reg[k] <= tex_next;
                ang_reg[k] <= ang_next;
                tag_reg[k] <= tag_prev;
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_ang   = ang_reg[STAGES-1];
    assign out_tex   = tex_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/uvs_cordic.sv
// Pipelined rotation-mode CORDIC: cosine and sine in Q2.30 of a phase in turns.
`default_nettype none

module uvs_cordic
    import uvs_pkg::*;
#(
    parameter int TAG_W = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [31:0]      phase,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_valid,
    output logic signed [31:0]    out_cos,
    output logic signed [31:0]    out_sin,
    output logic [TAG_W-1:0]      out_tag
);

    // pre-rotation, one stage per step, output sign fix
    localparam int STAGES = CORDIC_STEPS + 2;

    logic                 vld_reg  [STAGES];
    logic signed [CW-1:0] x_reg    [STAGES];
    logic signed [CW-1:0] y_reg    [STAGES];
    logic signed [CW-1:0] z_reg    [STAGES];
    logic                 flip_reg [STAGES];
    logic [TAG_W-1:0]     tag_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [CW-1:0] z_next;
        logic                 flip_next;
        logic [TAG_W-1:0]     tag_prev;
        logic                 vld_prev;

        if (k == 0) begin : g_pre
            logic signed [CW-1:0] z0;
            // fold the phase into +-quarter turn, remember the half-turn flip
            assign z0 = $signed({{(CW-32){phase[31]}}, phase});
            assign x_next = CORDIC_GAIN;
            assign y_next = '0;
            assign z_next = (z0 > QUARTER_TURN) ? z0 - HALF_TURN :
                            (z0 < -QUARTER_TURN) ? z0 + HALF_TURN : z0;
            assign flip_next = (z0 > QUARTER_TURN) || (z0 < -QUARTER_TURN);
            assign tag_prev = in_tag;
            assign vld_prev = in_valid;
        end else if (k <= CORDIC_STEPS) begin : g_step
            logic signed [CW-1:0] tx;
            logic signed [CW-1:0] ty;
            logic signed [CW-1:0] ang;
            logic                 ccw;
            assign tx  = shr_trunc(x_reg[k-1], k - 1);
            assign ty  = shr_trunc(y_reg[k-1], k - 1);
            assign ang = $signed({{(CW-32){1'b0}}, ATAN_TURNS[k-1]});
            assign ccw = !z_reg[k-1][CW-1];
            assign x_next = ccw ? x_reg[k-1] - ty : x_reg[k-1] + ty;
            assign y_next = ccw ? y_reg[k-1] + tx : y_reg[k-1] - tx;
            assign z_next = ccw ? z_reg[k-1] - ang : z_reg[k-1] + ang;
            assign flip_next = flip_reg[k-1];
            assign tag_prev = tag_reg[k-1];
            assign vld_prev = vld_reg[k-1];
        end else begin : g_fix
            assign x_next = flip_reg[k-1] ? -x_reg[k-1] : x_reg[k-1];
            assign y_next = flip_reg[k-1] ? -y_reg[k-1] : y_reg[k-1];
            assign z_next = z_reg[k-1];
            assign flip_next = 1'b0;
            assign tag_prev = tag_reg[k-1];
            assign vld_prev = vld_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                z_reg[k]    <= z_next;
                flip_reg[k] <= flip_next;
                tag_reg[k]  <= tag_prev;
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_cos   = 32'(x_reg[STAGES-1]);
    assign out_sin   = 32'(y_reg[STAGES-1]);
    assign out_tag   = tag_reg[STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/uvs_proj.sv
// Four-stage projection: angle products, radius scaling, rounding and saturation.
`default_nettype none

module uvs_proj
    import uvs_pkg::*;
#(
    parameter int TAG_W = 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] cos_u,
    input  wire logic signed [31:0] sin_u,
    input  wire logic signed [31:0] cos_v,
    input  wire logic signed [31:0] sin_v,
    input  wire logic [15:0]        radius,
    input  wire logic [TAG_W-1:0]   in_tag,
    output logic                    out_valid,
    output logic signed [16:0]      pos_x,
    output logic signed [16:0]      pos_y,
    output logic signed [16:0]      pos_z,
    output logic signed [15:0]      norm_x,
    output logic signed [15:0]      norm_y,
    output logic signed [15:0]      norm_z,
    output logic [TAG_W-1:0]        out_tag
);

    logic [3:0]       vld_reg;
    logic [TAG_W-1:0] tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg;

    // Stage A: angle products
    logic signed [63:0] cc_reg, cs_reg;
    logic signed [31:0] su_a_reg;
    // Stage B: products back to Q30
    logic signed [31:0] cucv_reg, cusv_reg, su_b_reg;
    // Stage C: radius products and normals
    logic signed [48:0] mx_reg, my_reg, mz_reg;
    logic signed [15:0] nx_c_reg, ny_c_reg, nz_c_reg;
    // Stage D: output registers
    logic signed [16:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;

    logic signed [63:0] cc_next, cs_next;
    logic signed [48:0] mx_next, my_next, mz_next;
    logic signed [16:0] rad_s;

    assign cc_next = cos_u * cos_v;
    assign cs_next = cos_u * sin_v;
    assign rad_s   = $signed({1'b0, radius});
    assign mx_next = rad_s * cucv_reg;
    assign my_next = rad_s * su_b_reg;
    assign mz_next = rad_s * cusv_reg;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            cc_reg    <= cc_next;
            cs_reg    <= cs_next;
            su_a_reg  <= sin_u;
            tag_a_reg <= in_tag;

            cucv_reg  <= 32'(shr_round64(cc_reg, 30));
            cusv_reg  <= 32'(shr_round64(cs_reg, 30));
            su_b_reg  <= su_a_reg;
            tag_b_reg <= tag_a_reg;

            mx_reg    <= mx_next;
            my_reg    <= my_next;
            mz_reg    <= mz_next;
            nx_c_reg  <= 16'(clamp_sym64(-shr_round64(64'(cucv_reg), 16), NORM_LIMIT));
            ny_c_reg  <= 16'(clamp_sym64(shr_round64(64'(su_b_reg), 16), NORM_LIMIT));
            nz_c_reg  <= 16'(clamp_sym64(shr_round64(64'(cusv_reg), 16), NORM_LIMIT));
            tag_c_reg <= tag_b_reg;

            px_reg    <= 17'(clamp_sym64(-shr_round64(64'(mx_reg), 30), POS_LIMIT));
            py_reg    <= 17'(clamp_sym64(shr_round64(64'(my_reg), 30), POS_LIMIT));
            pz_reg    <= 17'(clamp_sym64(shr_round64(64'(mz_reg), 30), POS_LIMIT));
            nx_reg    <= nx_c_reg;
            ny_reg    <= ny_c_reg;
            nz_reg    <= nz_c_reg;
            tag_d_reg <= tag_c_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign pos_x     = px_reg;
    assign pos_y     = py_reg;
    assign pos_z     = pz_reg;
    assign norm_x    = nx_reg;
    assign norm_y    = ny_reg;
    assign norm_z    = nz_reg;
    assign out_tag   = tag_d_reg;

endmodule

`default_nettype wire

FILE: rtl/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator: config registers and pipeline assembly.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    stack_index, sector_index
//  m_       out        m_valid / m_ready    position, normal, texture, index, flags
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One vertex per cycle sustained unless m_ready stalls; stages are an input register,
// a 33-stage long divider, a 26-stage CORDIC and a 4-stage multiply/round section.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the valid bits and loads the default counts and radius.
// cfg_ready is always high; a write takes effect on the next cycle.
`default_nettype none
`include "assert_macros.svh"

module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int MAX_SECTORS = 256,
    parameter int MAX_STACKS  = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [8:0]         s_stack_index,
    input  wire logic [8:0]         s_sector_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [16:0]      m_pos_x,
    output logic signed [16:0]      m_pos_y,
    output logic signed [16:0]      m_pos_z,
    output logic signed [15:0]      m_norm_x,
    output logic signed [15:0]      m_norm_y,
    output logic signed [15:0]      m_norm_z,
    output logic [16:0]             m_tex_s,
    output logic [16:0]             m_tex_t,
    output logic [16:0]             m_vertex_number,
    output logic                    m_upper_tri_valid,
    output logic                    m_lower_tri_valid,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    logic [8:0]  sector_count_reg;
    logic [8:0]  stack_count_reg;
    logic [15:0] sphere_radius_reg;

    // Config write decode
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_count_reg  <= SECTOR_COUNT_RST;
            stack_count_reg   <= STACK_COUNT_RST;
            sphere_radius_reg <= SPHERE_RADIUS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SECTOR_COUNT:  sector_count_reg  <= cfg_data[8:0];
                CFG_STACK_COUNT:   stack_count_reg   <= cfg_data[8:0];
                CFG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective counts, limited to the supported range
    logic [8:0] s_eff, t_eff;
    assign s_eff = (int'(sector_count_reg) > MAX_SECTORS) ? 9'(MAX_SECTORS) :
                   (sector_count_reg < MIN_SECTORS) ? MIN_SECTORS : sector_count_reg;
    assign t_eff = (int'(stack_count_reg) > MAX_STACKS) ? 9'(MAX_STACKS) :
                   (stack_count_reg < MIN_STACKS) ? MIN_STACKS : stack_count_reg;

    // Global advance: the last stage is the output register
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Input register with index clamping
    logic       in_vld_reg;
    logic [8:0] i_reg, j_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            i_reg <= (s_stack_index > t_eff) ? t_eff : s_stack_index;
            j_reg <= (s_sector_index > s_eff) ? s_eff : s_sector_index;
        end
    end

    // Vertex index and triangle flags
    logic [18:0] row_base;
    logic [16:0] vert_num;
    logic        in_grid, upper, lower, seam;
    assign row_base = 19'(i_reg) * 19'({1'b0, s_eff} + 10'd1);
    assign vert_num = 17'(row_base + 19'(j_reg));
    assign in_grid  = (i_reg < t_eff) && (j_reg < s_eff);
    assign upper    = in_grid && (i_reg != 9'd0);
    assign lower    = in_grid && (i_reg != 9'(t_eff - 9'd1));
    assign seam     = (j_reg == s_eff);

    // Dividers: longitude j/S and latitude i/T
    logic        dv_s_valid, dv_t_valid;
    logic [31:0] ang_s, ang_t;
    logic [16:0] tex_s, tex_t;
    logic [17:0] dv_s_tag;
    logic [1:0]  dv_t_tag;

    uvs_div #(.ANG_FRAC(32), .TAG_W(18)) u_div_sector (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (in_vld_reg),
        .num      (j_reg),
        .den      (s_eff),
        .in_tag   ({vert_num, seam}),
        .out_valid(dv_s_valid),
        .out_ang  (ang_s),
        .out_tex  (tex_s),
        .out_tag  (dv_s_tag)
    );

    uvs_div #(.ANG_FRAC(31), .TAG_W(2)) u_div_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (in_vld_reg),
        .num      (i_reg),
        .den      (t_eff),
        .in_tag   ({upper, lower}),
        .out_valid(dv_t_valid),
        .out_ang  (ang_t),
        .out_tex  (tex_t),
        .out_tag  (dv_t_tag)
    );

    // Phases: v from the sector, u is a quarter turn minus the stack's latitude angle
    logic [31:0] phase_v, phase_u;
    assign phase_v = dv_s_tag[0] ? 32'd0 : ang_s;
    assign phase_u = 32'h4000_0000 - ang_t;

    logic               cu_valid, cv_valid;
    logic signed [31:0] cos_u, sin_u, cos_v, sin_v;
    logic [18:0]        cu_tag;
    logic [33:0]        cv_tag;

    uvs_cordic #(.TAG_W(19)) u_cordic_u (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dv_s_valid && dv_t_valid),
        .phase    (phase_u),
        .in_tag   ({tex_t, dv_t_tag}),
        .out_valid(cu_valid),
        .out_cos  (cos_u),
        .out_sin  (sin_u),
        .out_tag  (cu_tag)
    );

    uvs_cordic #(.TAG_W(34)) u_cordic_v (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dv_s_valid && dv_t_valid),
        .phase    (phase_v),
        .in_tag   ({tex_s, dv_s_tag[17:1]}),
        .out_valid(cv_valid),
        .out_cos  (cos_v),
        .out_sin  (sin_v),
        .out_tag  (cv_tag)
    );

    // Tag order: tex_s, tex_t, vertex_number, upper, lower
    logic [52:0] out_tag;

    uvs_proj #(.TAG_W(53)) u_proj (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (cu_valid && cv_valid),
        .cos_u    (cos_u),
        .sin_u    (sin_u),
        .cos_v    (cos_v),
        .sin_v    (sin_v),
        .radius   (sphere_radius_reg),
        .in_tag   ({cv_tag[33:17], cu_tag[18:2], cv_tag[16:0], cu_tag[1:0]}),
        .out_valid(m_valid),
        .pos_x    (m_pos_x),
        .pos_y    (m_pos_y),
        .pos_z    (m_pos_z),
        .norm_x   (m_norm_x),
        .norm_y   (m_norm_y),
        .norm_z   (m_norm_z),
        .out_tag  (out_tag)
    );

    assign m_tex_s           = out_tag[52:36];
    assign m_tex_t           = out_tag[35:19];
    assign m_vertex_number   = out_tag[18:2];
    assign m_upper_tri_valid = out_tag[1];
    assign m_lower_tri_valid = out_tag[0];

    // Checks
    `UVS_ASSERT_ALWAYS(a_div_lockstep, aclk, aresetn, dv_s_valid == dv_t_valid, "dividers out of step")
    `UVS_ASSERT_ALWAYS(a_cordic_lockstep, aclk, aresetn, cu_valid == cv_valid, "CORDICs out of step")
    `UVS_ASSERT_IMPLY(a_norm_range, aclk, aresetn, m_valid, (m_norm_y <= 16'sd16384) && (m_norm_y >= -16'sd16384), "normal out of range")
    `UVS_ASSERT_IMPLY(a_upper_row, aclk, aresetn, m_valid && m_upper_tri_valid, m_tex_t != 17'd0, "upper triangle on pole row")

endmodule

`default_nettype wire
